### hw/rtl/fixed_chunk_free_list_allocator_top_macros.svh
// Assertion macros for the fixed chunk free list allocator.
`ifndef FIXED_CHUNK_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`define FIXED_CHUNK_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define FCFLA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fcfla check failed");
// Next-cycle implication, checked outside reset.
`define FCFLA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fcfla check failed");
`else
`define FCFLA_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define FCFLA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### hw/rtl/fcfla_pkg.sv
// Types and constants shared by the fixed chunk free list allocator.
`default_nettype none
package fcfla_pkg;

    localparam int IDX_W    = 9;   // widest chunk index (fresh mark reaches 510)
    localparam int CNT_W    = 9;   // in-use count, fresh mark, pool size
    localparam int BYTES_W  = 17;  // chunk size register
    localparam int OFFS_W   = 24;  // byte offset result
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // register indexes, decoded from paddr[2]
    localparam logic REG_POOL_CHUNKS = 1'b0;
    localparam logic REG_CHUNK_BYTES = 1'b1;

    localparam logic [CNT_W-1:0]   POOL_CHUNKS_RST = 9'd256;
    localparam logic [BYTES_W-1:0] CHUNK_BYTES_RST = 17'd64;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK          = 2'd0,
        STAT_EXHAUSTED   = 2'd1,
        STAT_FREE_REJECT = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] free_index;
    } t_in_beat;

    typedef struct packed {
        t_status           status;
        logic [7:0]        chunk_index;
        logic [OFFS_W-1:0] chunk_offset;
        logic [CNT_W-1:0]  in_use_count;
    } t_out_beat;

endpackage
`default_nettype wire

### hw/rtl/fixed_chunk_free_list_allocator_top.sv
// Fixed chunk pool allocator: LIFO free list with a fresh-chunk watermark.
//
// Usage:
//   Command beats enter on i_in_valid / o_in_stall with i_in_beat (cmd, free_index).
//   One result beat per command leaves on o_out_valid / i_out_stall with o_out_beat
//   (status, chunk_index, chunk_offset, in_use_count).
//   Allocate pops the free list head, or takes the next never-used chunk when the
//   list is empty; free pushes a chunk; clear rewinds the pool to ascending order.
//   Each beat passes through the input register, then the result register.
//   Throughput: one command per cycle while the receiver does not stall. The
//   link table is read at the next head every cycle, so the head's successor
//   is always waiting in a register; back-to-back allocates and frees do not stall.
//   When the receiver stalls, the result register holds; the input register
//   takes one more beat, then o_in_stall rises until the result moves.
//   Reset (synchronous, active low) empties the pool, clears the watermark and
//   count, and restores pool_chunks = 256 and chunk_bytes = 64. The link table
//   is not cleared; only entries written by a free are ever used.
//   Configuration goes through the APB port (pool_chunks at 0x0, chunk_bytes at
//   0x4); write it only while no command is in flight.
`default_nettype none
`include "fixed_chunk_free_list_allocator_top_macros.svh"

module fixed_chunk_free_list_allocator_top
    import fcfla_pkg::*;
#(
    parameter int MAX_CHUNKS = 256
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // command channel
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire t_in_beat            i_in_beat,
    // result channel
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output t_out_beat                o_out_beat,
    // configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    // Only indices below 256 can ever enter the list (free_index is 8 bits).
    localparam int LINK_DEPTH = (MAX_CHUNKS < 256) ? MAX_CHUNKS : 256;
    localparam int HEAD_W     = $clog2(LINK_DEPTH);
    localparam int CAP        = (MAX_CHUNKS > 511) ? 511 : MAX_CHUNKS;
    localparam logic [CNT_W-1:0] CAP_V = CNT_W'(CAP);

    // ---------------- configuration registers ----------------
    logic [CNT_W-1:0]   r_pool_chunks;
    logic [BYTES_W-1:0] r_chunk_bytes;
    logic               w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_chunks <= POOL_CHUNKS_RST;
            r_chunk_bytes <= CHUNK_BYTES_RST;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_POOL_CHUNKS: r_pool_chunks <= pwdata[CNT_W-1:0];
                REG_CHUNK_BYTES: r_chunk_bytes <= pwdata[BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_POOL_CHUNKS: prdata = PDATA_W'(r_pool_chunks);
            REG_CHUNK_BYTES: prdata = PDATA_W'(r_chunk_bytes);
            default:         prdata = '0;
        endcase
    end

    // ---------------- input register ----------------
    // free_index mod MAX_CHUNKS through a constant table.
    logic [HEAD_W-1:0] w_mod_tbl [256];
    for (genvar g = 0; g < 256; g++) begin : g_mod
        assign w_mod_tbl[g] = HEAD_W'(g % MAX_CHUNKS);
    end

    logic              r_in_vld;
    t_cmd              r_in_cmd;
    logic [HEAD_W-1:0] r_in_f;
    logic              w_out_ready;
    logic              w_proc;

    assign w_out_ready = !o_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_vld && !w_out_ready;
    assign w_proc      = r_in_vld && w_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_cmd <= i_in_beat.cmd;
            r_in_f   <= w_mod_tbl[i_in_beat.free_index];
        end
    end

    // ---------------- pool state ----------------
    logic [HEAD_W-1:0] r_head, n_head;
    logic [HEAD_W-1:0] r_next;          // link_table[r_head], kept current
    logic              r_list_nonempty, n_list_nonempty;
    logic [CNT_W-1:0]  r_fresh, n_fresh;
    logic [CNT_W-1:0]  r_used, n_used;
    logic [CNT_W-1:0]  w_eff;
    logic              w_link_wr;
    logic [IDX_W-1:0]  w_idx;
    logic [IDX_W+BYTES_W-1:0] w_prod;
    t_out_beat         n_out;
    t_out_beat         r_out;
    logic              r_out_vld;

    logic [HEAD_W-1:0] r_link [LINK_DEPTH];

    assign w_eff = (r_pool_chunks < CAP_V) ? r_pool_chunks : CAP_V;

    always_comb begin
        n_head          = r_head;
        n_list_nonempty = r_list_nonempty;
        n_fresh         = r_fresh;
        n_used          = r_used;
        w_link_wr       = 1'b0;
        w_idx           = '0;
        n_out.status    = STAT_OK;
        if (w_proc) begin
            case (r_in_cmd)
                CMD_ALLOC: begin
                    if (r_used >= w_eff) begin
                        n_out.status = STAT_EXHAUSTED;
                    end else if (r_list_nonempty) begin
                        w_idx           = IDX_W'(r_head);
                        n_head          = r_next;
                        n_used          = r_used + 1'b1;
                        n_list_nonempty = r_fresh > n_used;
                    end else begin
                        w_idx   = r_fresh;
                        n_fresh = r_fresh + 1'b1;
                        n_used  = r_used + 1'b1;
                    end
                end
                CMD_FREE: begin
                    if (r_used == '0) begin
                        n_out.status = STAT_FREE_REJECT;
                    end else begin
                        w_link_wr       = 1'b1;
                        n_head          = r_in_f;
                        n_list_nonempty = 1'b1;
                        n_used          = r_used - 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    n_head          = '0;
                    n_list_nonempty = 1'b0;
                    n_fresh         = '0;
                    n_used          = '0;
                end
                default: ;
            endcase
        end
        w_prod             = w_idx * r_chunk_bytes;
        n_out.chunk_index  = w_idx[7:0];
        n_out.chunk_offset = w_prod[OFFS_W-1:0];
        n_out.in_use_count = n_used;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head          <= '0;
            r_list_nonempty <= 1'b0;
            r_fresh         <= '0;
            r_used          <= '0;
        end else begin
            r_head          <= n_head;
            r_list_nonempty <= n_list_nonempty;
            r_fresh         <= n_fresh;
            r_used          <= n_used;
        end
    end

    // link table: push writes old head at the freed index; read tracks next head
    always_ff @(posedge i_clk) begin
        if (w_link_wr) begin
            r_link[r_in_f] <= r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_link_wr) begin
            r_next <= r_head;   // freed chunk becomes head, its link is old head
        end else begin
            r_next <= r_link[n_head];
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_ready) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out;

    // ---------------- checks ----------------
    `FCFLA_ASSERT_IMPL(a_list_matches_mark, i_clk, i_rst_n, 1'b1,
        r_list_nonempty == (r_fresh > r_used))
    `FCFLA_ASSERT_IMPL(a_used_within_mark, i_clk, i_rst_n, 1'b1, r_used <= r_fresh)
    `FCFLA_ASSERT_IMPL(a_reject_only_empty, i_clk, i_rst_n,
        o_out_valid && (o_out_beat.status == STAT_FREE_REJECT),
        o_out_beat.in_use_count == '0)
    `FCFLA_ASSERT_NEXT(a_alloc_counts_up, i_clk, i_rst_n,
        w_proc && (r_in_cmd == CMD_ALLOC) && (r_used < w_eff),
        r_used == $past(r_used) + 1'b1)

endmodule
`default_nettype wire

### test/tb_fixed_chunk_free_list_allocator_top.sv
// Testbench for the fixed chunk free list allocator: directed table plus random command streams.
`timescale 1ns / 100ps

module tb_fixed_chunk_free_list_allocator_top
    import fcfla_pkg::*;
();

    localparam int CLK_PERIOD  = 8;
    localparam int CHUNK_SLOTS = 256;      // MAX_CHUNKS of the instance
    localparam int CYCLE_LIMIT = 400000;   // far above the slowest legal run
    localparam int PHASE_BEATS = 380;      // random beats per idling phase
    localparam int DIR_ROWS    = 24;

    // cmd code 3 is not decoded; the block must leave the pool alone
    localparam t_cmd CMD_UNUSED = t_cmd'(2'd3);

    // ------------------------------------------------------------------
    // Clock, reset and DUT signals
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    t_in_beat            i_in_beat;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_beat           o_out_beat;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    fixed_chunk_free_list_allocator_top #(
        .MAX_CHUNKS (CHUNK_SLOTS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------
    // Pool shadow: our own copy of the free list, watermark and registers
    // ------------------------------------------------------------------
    logic [7:0]  chunk_links [CHUNK_SLOTS];
    logic [7:0]  list_head;
    logic        list_has_entries;
    logic [8:0]  fresh_chunk;
    logic [8:0]  chunks_in_use;
    logic [8:0]  pool_chunks_cfg;
    logic [16:0] chunk_bytes_cfg;

    t_out_beat   pending_results [$];   // expected result beats, oldest first
    logic [7:0]  held_chunks [$];       // chunks handed out and not yet returned

    int err_count   = 0;
    int cycle_count = 0;
    int send_idle_pct;                  // sender idle chance per cycle, percent
    int recv_idle_pct;                  // receiver stall chance per cycle, percent
    int alloc_pct;                      // share of allocates in random commands
    int clear_pct;                      // share of clears in random commands
    int phase_beats;

    // Work out the result of one accepted command and advance the shadow.
    task automatic apply_command(input t_in_beat b, output t_out_beat r);
        logic [8:0]  eff_chunks;
        logic [31:0] product;
        eff_chunks = (pool_chunks_cfg < CHUNK_SLOTS) ? pool_chunks_cfg : 9'(CHUNK_SLOTS);
        r = '0;
        r.status = STAT_OK;
        case (b.cmd)
            CMD_ALLOC: begin
                if (chunks_in_use >= eff_chunks) begin
                    r.status = STAT_EXHAUSTED;
                end else begin
                    if (list_has_entries) begin
                        // pop the list head; its link was written by the free that pushed it
                        r.chunk_index    = list_head;
                        list_head        = chunk_links[list_head];
                        chunks_in_use    = chunks_in_use + 9'd1;
                        list_has_entries = (fresh_chunk > chunks_in_use);
                    end else begin
                        // list empty: hand out the next never-used chunk
                        r.chunk_index = fresh_chunk[7:0];
                        fresh_chunk   = fresh_chunk + 9'd1;
                        chunks_in_use = chunks_in_use + 9'd1;
                    end
                    product        = 32'(r.chunk_index) * 32'(chunk_bytes_cfg);
                    r.chunk_offset = product[OFFS_W-1:0];
                    held_chunks.push_back(r.chunk_index);
                end
            end
            CMD_FREE: begin
                if (chunks_in_use == 9'd0) begin
                    r.status = STAT_FREE_REJECT;
                end else begin
                    // pushed unchecked: double frees come back out later
                    chunk_links[b.free_index] = list_head;
                    list_head                 = b.free_index;
                    list_has_entries          = 1'b1;
                    chunks_in_use             = chunks_in_use - 9'd1;
                end
            end
            CMD_CLEAR: begin
                list_head        = '0;
                list_has_entries = 1'b0;
                fresh_chunk      = '0;
                chunks_in_use    = '0;
                held_chunks.delete();
            end
            default: ;
        endcase
        r.in_use_count = chunks_in_use;
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        err_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing pending, status",
                                o_out_beat.status, -1);
            end else begin
                want = pending_results.pop_front();
                if (o_out_beat.status !== want.status)
                    report_mismatch("status", o_out_beat.status, want.status);
                if (o_out_beat.chunk_index !== want.chunk_index)
                    report_mismatch("chunk_index", o_out_beat.chunk_index, want.chunk_index);
                if (o_out_beat.chunk_offset !== want.chunk_offset)
                    report_mismatch("chunk_offset", o_out_beat.chunk_offset,
                                    want.chunk_offset);
                if (o_out_beat.in_use_count !== want.in_use_count)
                    report_mismatch("in_use_count", o_out_beat.in_use_count,
                                    want.in_use_count);
            end
        end
    end

    // Receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Watchdog: a hang or a lost result ends here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers; all driving happens just after a rising edge
    // ------------------------------------------------------------------

    // Offer one command beat, idling first at random; predict on acceptance.
    // A literal expectation, where given, replaces the shadow's answer.
    task automatic send_command(input t_in_beat b, input bit use_lit, input t_out_beat lit_want);
        t_out_beat predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        apply_command(b, predicted);
        pending_results.push_back(use_lit ? lit_want : predicted);
    endtask

    // Stop sending and wait until every pending result has left the block.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);   // margin after the last result
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_register(input logic reg_sel, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (reg_sel == REG_POOL_CHUNKS)
            pool_chunks_cfg = value[8:0];
        else
            chunk_bytes_cfg = value[16:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly well-formed traffic: frees usually return a chunk we hold.
    task automatic random_command(output t_in_beat b);
        int r;
        int k;
        r            = $urandom_range(0, 99);
        b.free_index = 8'($urandom_range(0, 255));   // noise on the unused field too
        if (r < clear_pct) begin
            b.cmd = CMD_CLEAR;
        end else if (r < clear_pct + 2) begin
            b.cmd = CMD_UNUSED;
        end else if (r < clear_pct + 2 + alloc_pct) begin
            b.cmd = CMD_ALLOC;
        end else begin
            b.cmd = CMD_FREE;
            if (held_chunks.size() != 0 && $urandom_range(0, 9) < 8) begin
                k            = $urandom_range(0, held_chunks.size() - 1);
                b.free_index = held_chunks[k];
                held_chunks.delete(k);
            end
        end
    endtask

    // One stretch of traffic under one register setting.
    task automatic run_segment(input logic [8:0] pool, input logic [16:0] bytes,
                               input int allocs, input int clears, input int beats,
                               input bit clear_first);
        t_in_beat b;
        wait_for_drain();
        write_register(REG_POOL_CHUNKS, 32'(pool));
        write_register(REG_CHUNK_BYTES, 32'(bytes));
        alloc_pct = allocs;
        clear_pct = clears;
        if (clear_first) begin
            b.cmd        = CMD_CLEAR;
            b.free_index = 8'($urandom_range(0, 255));
            send_command(b, 1'b0, '0);
            phase_beats++;
        end
        repeat (beats) begin
            random_command(b);
            send_command(b, 1'b0, '0);
            phase_beats++;
        end
    endtask

    // Random register setting, weighted toward small pools and the extremes.
    task automatic random_segment();
        logic [8:0]  pool;
        logic [16:0] bytes;
        case ($urandom_range(0, 9))
            0:       pool = 9'd1;
            1:       pool = 9'd2;
            2, 3, 4: pool = 9'($urandom_range(1, 16));
            5, 6:    pool = 9'($urandom_range(17, 256));
            7:       pool = 9'd256;
            8:       pool = 9'($urandom_range(257, 511));
            default: pool = 9'd0;
        endcase
        case ($urandom_range(0, 5))
            0:       bytes = 17'd1;
            1:       bytes = 17'd65536;
            2:       bytes = 17'h1FFFF;
            default: bytes = 17'($urandom_range(1, 131071));
        endcase
        run_segment(pool, bytes, $urandom_range(30, 90), $urandom_range(0, 3),
                    $urandom_range(40, 120), ($urandom_range(0, 3) == 0));
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct packed {
        bit        lit;    // expectation typed in below
        t_in_beat  beat;
        t_out_beat want;
    } t_dir_row;

    function automatic t_dir_row mk_row(input t_cmd c, input logic [7:0] fi, input bit lit,
                                        input t_status st, input logic [7:0] ci,
                                        input logic [OFFS_W-1:0] off,
                                        input logic [CNT_W-1:0] cnt);
        t_dir_row row;
        row.lit                = lit;
        row.beat.cmd           = c;
        row.beat.free_index    = fi;
        row.want.status        = st;
        row.want.chunk_index   = ci;
        row.want.chunk_offset  = off;
        row.want.in_use_count  = cnt;
        return row;
    endfunction

    t_dir_row dir_rows [DIR_ROWS];

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // everything known from time zero
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_beat     = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        send_idle_pct = 30;
        recv_idle_pct = 0;
        alloc_pct     = 50;
        clear_pct     = 2;
        phase_beats   = 0;

        // shadow after reset
        foreach (chunk_links[i]) chunk_links[i] = '0;
        list_head        = '0;
        list_has_entries = 1'b0;
        fresh_chunk      = '0;
        chunks_in_use    = '0;
        pool_chunks_cfg  = POOL_CHUNKS_RST;
        chunk_bytes_cfg  = CHUNK_BYTES_RST;

        // Reset-state walk: literals only where the answer is obvious.
        dir_rows = '{
            mk_row(CMD_ALLOC,  8'd0,   1, STAT_OK,          8'd0, 24'd0,  9'd1),
            mk_row(CMD_FREE,   8'd0,   1, STAT_OK,          8'd0, 24'd0,  9'd0),
            // free with nothing out is refused
            mk_row(CMD_FREE,   8'd5,   1, STAT_FREE_REJECT, 8'd0, 24'd0,  9'd0),
            mk_row(CMD_UNUSED, 8'd255, 1, STAT_OK,          8'd0, 24'd0,  9'd0),
            mk_row(CMD_ALLOC,  8'd0,   0, STAT_OK,          8'd0, 24'd0,  9'd0),
            mk_row(CMD_ALLOC,  8'd0,   0, STAT_OK,          8'd0, 24'd0,  9'd0),
            // never-allocated top index goes on the list, then comes out
            mk_row(CMD_FREE,   8'd255, 0, STAT_OK,          8'd0, 24'd0,  9'd0),
            mk_row(CMD_ALLOC,  8'd0,   0, STAT_OK,          8'd0, 24'd0,  9'd0),
            mk_row(CMD_FREE,   8'hAA,  0, STAT_OK,          8'd0, 24'd0,  9'd0),
            mk_row(CMD_FREE,   8'h55,  0, STAT_OK,          8'd0, 24'd0,  9'd0),
            mk_row(CMD_ALLOC,  8'h00,  0, STAT_OK,          8'd0, 24'd0,  9'd0),
            mk_row(CMD_ALLOC,  8'hFF,  0, STAT_OK,          8'd0, 24'd0,  9'd0),
            mk_row(CMD_ALLOC,  8'h00,  0, STAT_OK,          8'd0, 24'd0,  9'd0),
            mk_row(CMD_CLEAR,  8'hAA,  1, STAT_OK,          8'd0, 24'd0,  9'd0),
            // ascending order again after clear
            mk_row(CMD_ALLOC,  8'd0,   1, STAT_OK,          8'd0, 24'd0,  9'd1),
            mk_row(CMD_ALLOC,  8'd0,   1, STAT_OK,          8'd1, 24'd64, 9'd2),
            // double free of chunk 1: it is handed out twice below
            mk_row(CMD_FREE,   8'd1,   0, STAT_OK,          8'd0, 24'd0,  9'd0),
            mk_row(CMD_FREE,   8'd1,   0, STAT_OK,          8'd0, 24'd0,  9'd0),
            mk_row(CMD_FREE,   8'd9,   1, STAT_FREE_REJECT, 8'd0, 24'd0,  9'd0),
            mk_row(CMD_ALLOC,  8'd0,   0, STAT_OK,          8'd0, 24'd0,  9'd0),
            mk_row(CMD_ALLOC,  8'd0,   0, STAT_OK,          8'd0, 24'd0,  9'd0),
            mk_row(CMD_CLEAR,  8'd0,   1, STAT_OK,          8'd0, 24'd0,  9'd0),
            mk_row(CMD_UNUSED, 8'd0,   1, STAT_OK,          8'd0, 24'd0,  9'd0),
            mk_row(CMD_ALLOC,  8'd0,   1, STAT_OK,          8'd0, 24'd0,  9'd1)
        };

        // Phase A: sender idles 30 %, receiver stalls 71 %
        send_idle_pct = 30;
        recv_idle_pct = 71;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_command(dir_rows[i].beat, dir_rows[i].lit, dir_rows[i].want);

        // hold-off: sender waits for every result before moving on
        wait_for_drain();

        // Corner settings first: empty pool, one chunk, clamped count with
        // offset wrap (fills all 256 chunks), then shrink while chunks are out.
        phase_beats = 0;
        run_segment(9'd0,   17'd1,     60,  2, 20,  1'b0);
        run_segment(9'd1,   17'd65536, 60,  2, 30,  1'b1);
        run_segment(9'd511, 17'h1FFFF, 100, 0, 262, 1'b1);
        run_segment(9'd3,   17'd1,     40,  0, 40,  1'b0);
        while (phase_beats < PHASE_BEATS) random_segment();

        // Phase B: roles swapped
        wait_for_drain();
        send_idle_pct = 71;
        recv_idle_pct = 30;
        phase_beats   = 0;
        while (phase_beats < PHASE_BEATS) random_segment();

        // Phase C: full rate both ways, back to the reset setting at the end
        wait_for_drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        phase_beats   = 0;
        while (phase_beats < PHASE_BEATS) random_segment();
        run_segment(POOL_CHUNKS_RST, CHUNK_BYTES_RST, 70, 1, 60, 1'b0);

        wait_for_drain();
        repeat (4) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
